// ===== src/efla_pkg.sv =====
// Shared types, constants and link reset function of the entry free-list allocator.
package efla_pkg;

    // Pool size and derived widths.
    localparam int ENTRIES = 64;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int PTR_W   = ADDR_W + 1;

    // Fixed widths of the request and response fields.
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    // Request codes.
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Pointer value that ends a list.
    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(ENTRIES);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_RANGE    = 2'd2,
        STATUS_NOT_USED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC_WR,
        ST_HEAD_WR,
        ST_WALK,
        ST_UNLINK_WR,
        ST_FREE_WR,
        ST_DONE
    } t_state;

    // Access request from the sequencer to the link table.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [PTR_W-1:0]  wr_data;
    } t_link_req;

    // Next pointer of an entry after reset: a chain from entry 1 to the last
    // entry, with entry 0 and the last entry ending their lists.
    function automatic logic [PTR_W-1:0] link_reset(input logic [ADDR_W-1:0] addr);
        logic [PTR_W-1:0] ptr;
        if (addr == ADDR_W'(0) || addr == ADDR_W'(ENTRIES - 1)) begin
            ptr = NIL_PTR;
        end else begin
            ptr = PTR_W'(addr) + PTR_W'(1);
        end
        return ptr;
    endfunction

endpackage

// ===== src/efla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module efla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/efla_link_table.sv =====
// Next-pointer table: RAM plus per-entry valid bits that stand in for the reset chain.
module efla_link_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  efla_pkg::t_link_req      i_req,
    output logic [efla_pkg::PTR_W-1:0] o_rd_data
);

    import efla_pkg::*;

    logic [ENTRIES-1:0] r_valid;
    logic [ADDR_W-1:0]  r_rd_addr;
    logic               r_rd_hit;
    logic [PTR_W-1:0]   ram_q;

    efla_ram #(
        .WIDTH (PTR_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_req.wr_en),
        .i_wr_addr (i_req.wr_addr),
        .i_wr_data (i_req.wr_data),
        .i_rd_en   (i_req.rd_en),
        .i_rd_addr (i_req.rd_addr),
        .o_rd_data (ram_q)
    );

    // An entry becomes valid once it has been written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // Track the address and validity of the read in flight.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_addr <= i_req.rd_addr;
            r_rd_hit  <= r_valid[i_req.rd_addr];
        end
    end

    // Entries never written read as their reset pointer.
    assign o_rd_data = r_rd_hit ? ram_q : link_reset(r_rd_addr);

endmodule

// ===== src/entry_free_list_allocator.sv =====
// Top level of the entry free-list allocator: request sequencer, list heads and response register.
//
//  Channel   | Handshake                 | Payload
//  ----------+---------------------------+-----------------------------------------------
//  request   | i_in_valid / o_in_ready   | i_req_type, i_entry_index
//  response  | o_out_valid / i_out_ready | o_granted_index, o_status, o_free_count
//
// Refused requests go from idle straight to the response load; an allocate passes through
// ST_ALLOC_WR and a release of the used head through ST_HEAD_WR; a walked release stays in
// ST_WALK for each link walked and, if found, passes through ST_UNLINK_WR and ST_FREE_WR,
// paced by the single read port of the link table.
// A new request is taken once the sequencer is idle, even while the last response waits;
// a stalled response holds the next one in the sequencer. Reset marks all links unwritten.
module entry_free_list_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_req_type,
    input  logic [efla_pkg::IDX_W-1:0]  i_entry_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [efla_pkg::IDX_W-1:0]  o_granted_index,
    output logic [1:0]                  o_status,
    output logic [efla_pkg::CNT_W-1:0]  o_free_count
);

    import efla_pkg::*;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_free_head, n_free_head;
    logic [PTR_W-1:0]   r_used_head, n_used_head;
    logic [PTR_W-1:0]   r_free_total, n_free_total;
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [PTR_W-1:0]   r_pre, n_pre;
    logic [PTR_W-1:0]   r_steps, n_steps;
    logic [IDX_W-1:0]   r_res_granted, n_res_granted;
    t_status            r_res_status, n_res_status;
    logic [IDX_W-1:0]   r_out_granted, n_out_granted;
    t_status            r_out_status, n_out_status;
    logic [CNT_W-1:0]   r_out_count, n_out_count;

    t_link_req          link_req;
    logic [PTR_W-1:0]   link_q;
    logic [PTR_W-1:0]   total_inc;

    efla_link_table u_link_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (link_req),
        .o_rd_data (link_q)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_free_head  <= PTR_W'(1);
            r_used_head  <= '0;
            r_free_total <= PTR_W'(ENTRIES - 1);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_used_head  <= n_used_head;
            r_free_total <= n_free_total;
            r_out_valid  <= n_out_valid;
        end
    end

    // Working and response payload registers.
    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_pre         <= n_pre;
        r_steps       <= n_steps;
        r_res_granted <= n_res_granted;
        r_res_status  <= n_res_status;
        r_out_granted <= n_out_granted;
        r_out_status  <= n_out_status;
        r_out_count   <= n_out_count;
    end

    // The free count saturates at the pool size.
    assign total_inc = (r_free_total < PTR_W'(ENTRIES)) ? r_free_total + PTR_W'(1)
                                                         : r_free_total;

    // Sequencer: next state, list updates and link table accesses.
    always_comb begin
        n_state       = r_state;
        n_free_head   = r_free_head;
        n_used_head   = r_used_head;
        n_free_total  = r_free_total;
        n_out_valid   = r_out_valid;
        n_idx         = r_idx;
        n_pre         = r_pre;
        n_steps       = r_steps;
        n_res_granted = r_res_granted;
        n_res_status  = r_res_status;
        n_out_granted = r_out_granted;
        n_out_status  = r_out_status;
        n_out_count   = r_out_count;
        link_req      = '0;

        // The response register empties on its transfer.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_idx         = i_entry_index;
                    n_res_granted = '0;
                    if (i_req_type == REQ_ALLOC) begin
                        if (r_free_total == '0 || r_free_head >= PTR_W'(ENTRIES)) begin
                            n_res_status = STATUS_EMPTY;
                            n_state      = ST_DONE;
                        end else begin
                            link_req.rd_en   = 1'b1;
                            link_req.rd_addr = ADDR_W'(r_free_head);
                            n_state          = ST_ALLOC_WR;
                        end
                    end else if (PTR_W'(i_entry_index) >= PTR_W'(ENTRIES)) begin
                        n_res_status = STATUS_RANGE;
                        n_state      = ST_DONE;
                    end else if (r_used_head == PTR_W'(i_entry_index)) begin
                        link_req.rd_en   = 1'b1;
                        link_req.rd_addr = ADDR_W'(i_entry_index);
                        n_state          = ST_HEAD_WR;
                    end else if (r_used_head >= PTR_W'(ENTRIES)) begin
                        n_res_status = STATUS_NOT_USED;
                        n_state      = ST_DONE;
                    end else begin
                        link_req.rd_en   = 1'b1;
                        link_req.rd_addr = ADDR_W'(r_used_head);
                        n_pre            = r_used_head;
                        n_steps          = '0;
                        n_state          = ST_WALK;
                    end
                end
            end

            // Pop the free head and push it on the used list.
            ST_ALLOC_WR: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = ADDR_W'(r_free_head);
                link_req.wr_data = r_used_head;
                n_free_head      = link_q;
                n_used_head      = r_free_head;
                n_free_total     = r_free_total - PTR_W'(1);
                n_res_granted    = IDX_W'(r_free_head);
                n_res_status     = STATUS_OK;
                n_state          = ST_DONE;
            end

            // The released entry is the used head: advance the head, then free it.
            ST_HEAD_WR: begin
                n_used_head      = link_q;
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = ADDR_W'(r_idx);
                link_req.wr_data = r_free_head;
                n_free_head      = PTR_W'(r_idx);
                n_free_total     = total_inc;
                n_res_status     = STATUS_OK;
                n_state          = ST_DONE;
            end

            // One link per cycle: link_q holds the successor of the entry at r_pre.
            ST_WALK: begin
                if (link_q == PTR_W'(r_idx)) begin
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = ADDR_W'(r_idx);
                    n_state          = ST_UNLINK_WR;
                end else if (r_steps + PTR_W'(1) == PTR_W'(ENTRIES) ||
                             link_q >= PTR_W'(ENTRIES)) begin
                    n_res_status = STATUS_NOT_USED;
                    n_state      = ST_DONE;
                end else begin
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = ADDR_W'(link_q);
                    n_pre            = link_q;
                    n_steps          = r_steps + PTR_W'(1);
                end
            end

            // Bridge the predecessor over the released entry.
            ST_UNLINK_WR: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = ADDR_W'(r_pre);
                link_req.wr_data = link_q;
                n_state          = ST_FREE_WR;
            end

            // Push the released entry on the free list.
            ST_FREE_WR: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = ADDR_W'(r_idx);
                link_req.wr_data = r_free_head;
                n_free_head      = PTR_W'(r_idx);
                n_free_total     = total_inc;
                n_res_status     = STATUS_OK;
                n_state          = ST_DONE;
            end

            // Load the response once the output register is free.
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_granted = r_res_granted;
                    n_out_status  = r_res_status;
                    n_out_count   = CNT_W'(r_free_total);
                    n_state       = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_granted_index = r_out_granted;
    assign o_status        = r_out_status;
    assign o_free_count    = r_out_count;

endmodule
